>>> hw/rtl/lph_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lph_pkg - shared definitions for the linear-probe hash table
// Field widths, operation / mark / status codes, and the command and status
// bundles passed between controller and datapath.
// ============================================================================
package lph_pkg;

  localparam int TABLE_SIZE_DEF = 16;

  localparam int FUNC_W = 2;
  localparam int KEY_W  = 31;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 4;
  localparam int MARK_W = 2;

  // home-slot reduction: reciprocal multiply, then a short remainder step
  localparam int HASH_STEPS = 2;
  localparam int STEP_W     = $clog2(HASH_STEPS);

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;

  localparam logic [MARK_W-1:0] MK_EMPTY   = 2'd0;
  localparam logic [MARK_W-1:0] MK_USED    = 2'd1;
  localparam logic [MARK_W-1:0] MK_DELETED = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic clr_step;
    logic hash_start;
    logic hash_step;
    logic probe_start;
    logic probe_run;
    logic mem_we;
    logic res_load;
    logic out_load;
  } lph_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hash_last;
    logic func_ok;
    logic func_mod;
    logic probe_end;
    logic probe_hit;
  } lph_sts_t;

endpackage

>>> hw/rtl/lph_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// lph_ctrl - sequencing state machine
// Runs the clear pass, then per item: accept, home-slot reduction, probe (skipped
// for an unused opcode), result hand-off into the output register.
// ============================================================================
module lph_ctrl
  import lph_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     out_stall,
  output logic     out_valid,
  input  lph_sts_t sts,
  output lph_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_PROBE  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.hash_start = 1'b1;
          state_nxt      = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_last) begin
          if (sts.func_ok) begin
            cmd.probe_start = 1'b1;
            state_nxt       = S_PROBE;
          end else begin
            // unused opcode: answer not-found without touching the table
            cmd.res_load = 1'b1;
            state_nxt    = S_RESULT;
          end
        end
      end
      S_PROBE: begin
        cmd.probe_run = 1'b1;
        if (sts.probe_end) begin
          cmd.res_load = 1'b1;
          cmd.mem_we   = sts.probe_hit & sts.func_mod;
          state_nxt    = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/lph_dpath.sv
`timescale 1ns / 1ps
// ============================================================================
// lph_dpath - table memory, home-slot reduction and probe pipeline
// One memory word per slot holds {mark, key}. Reads are registered, so the
// probe issues one address per cycle and checks it in the next cycle.
// ============================================================================
module lph_dpath
  import lph_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [KEY_W-1:0]  in_key,
  input  lph_cmd_t          cmd,
  output lph_sts_t          sts,
  output logic [STAT_W-1:0] out_status,
  output logic [SLOT_W-1:0] out_slot
);

  localparam int AW     = $clog2(TABLE_SIZE);
  localparam int CW     = $clog2(TABLE_SIZE + 1);
  localparam int WORD_W = MARK_W + KEY_W;
  localparam int PROD_W = 2 * KEY_W + 1;
  // rounded-up reciprocal: (key * RECIP) >> (KEY_W + AW) is the exact
  // quotient for every KEY_W-bit key
  localparam logic [KEY_W:0] RECIP =
    (KEY_W + 1)'(((64'd1 << (KEY_W + AW)) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE));
  localparam logic [AW-1:0] TS_LOW   = AW'(TABLE_SIZE);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(TABLE_SIZE);
  localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_SIZE - 1);

  logic [WORD_W-1:0] mem [TABLE_SIZE];

  logic [FUNC_W-1:0] func_r;
  logic [KEY_W-1:0]  key_r;
  logic [STEP_W-1:0] dig_r;
  logic [AW-1:0]     quo_r, rem_step;
  logic [AW-1:0]     clr_r;
  logic [AW-1:0]     raddr_r, raddr_next;
  logic [AW-1:0]     eaddr_r;
  logic [CW-1:0]     icnt_r, ecnt_r;
  logic              rv_r;
  logic [WORD_W-1:0] rdata_r;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic [SLOT_W-1:0] out_slot_r;

  logic [PROD_W-1:0] prod;
  logic              issue;
  logic              is_ins;
  logic [MARK_W-1:0] mark;
  logic [KEY_W-1:0]  skey;
  logic              hit, miss_empty, lap;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;

  // quotient by reciprocal multiply; only its low AW bits are kept
  assign prod = PROD_W'(key_r) * PROD_W'(RECIP);

  // remainder < TABLE_SIZE <= 2^AW, so the low AW bits of key - q*N suffice
  assign rem_step = key_r[AW-1:0] - (quo_r * TS_LOW);

  assign raddr_next = (raddr_r == LAST_IDX) ? '0 : raddr_r + 1'b1;
  assign issue      = (icnt_r != CNT_FULL);

  // probe check on the word read last cycle
  assign is_ins     = (func_r == FN_INSERT);
  assign mark       = rdata_r[KEY_W +: MARK_W];
  assign skey       = rdata_r[KEY_W-1:0];
  assign hit        = rv_r & (is_ins ? (mark != MK_USED)
                                     : ((mark == MK_USED) && (skey == key_r)));
  assign miss_empty = rv_r & ~is_ins & (mark == MK_EMPTY);
  assign lap        = rv_r & (ecnt_r == CNT_LAST);

  assign sts.clr_last  = (clr_r == LAST_IDX);
  assign sts.hash_last = (dig_r == STEP_W'(HASH_STEPS - 1));
  assign sts.func_ok   = (func_r == FN_INSERT) || (func_r == FN_SEARCH) ||
                         (func_r == FN_DELETE);
  assign sts.func_mod  = (func_r == FN_INSERT) || (func_r == FN_DELETE);
  assign sts.probe_end = hit | miss_empty | lap;
  assign sts.probe_hit = hit;

  assign res_status_nxt = hit ? ST_OK : (is_ins ? ST_FULL : ST_NOT_FOUND);
  assign res_slot_nxt   = hit ? SLOT_W'(eaddr_r) : '0;

  assign we    = cmd.clr_step | cmd.mem_we;
  assign waddr = cmd.clr_step ? clr_r : eaddr_r;
  assign wdata = cmd.clr_step ? {MK_EMPTY, {KEY_W{1'b0}}}
                              : {(is_ins ? MK_USED : MK_DELETED), key_r};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      rv_r  <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.probe_start) begin
        rv_r <= 1'b0;
      end else begin
        rv_r <= cmd.probe_run & issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hash_start) begin
      func_r <= in_func;
      key_r  <= in_key;
      dig_r  <= '0;
    end else if (cmd.hash_step) begin
      quo_r <= prod[KEY_W + AW +: AW];
      dig_r <= dig_r + 1'b1;
    end
    if (cmd.probe_start) begin
      raddr_r <= rem_step;
      icnt_r  <= '0;
      ecnt_r  <= '0;
    end else if (cmd.probe_run) begin
      if (issue) begin
        raddr_r <= raddr_next;
        eaddr_r <= raddr_r;
        icnt_r  <= icnt_r + 1'b1;
      end
      if (rv_r) begin
        ecnt_r <= ecnt_r + 1'b1;
      end
    end
    if (cmd.res_load) begin
      res_status_r <= res_status_nxt;
      res_slot_r   <= res_slot_nxt;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
    end
  end

  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

endmodule

>>> hw/rtl/linear_probe_hash_table_core.sv
`timescale 1ns / 1ps
// ============================================================================
// linear_probe_hash_table_core - open-addressed hash table, linear probing
// Insert / search / delete of 31-bit keys with deleted-slot reuse.
// ============================================================================
// Usage:
//   Input channel  in_valid / in_stall carries one item: in_func (0 insert,
//   1 search, 2 delete) and in_key. Result channel out_valid / out_stall
//   carries out_status (0 ok, 1 not found, 2 full) and out_slot.
//   An item moves on an edge where valid is high and stall is low.
//   Every item produces exactly one result, in order.
// Per item:
//   The key is reduced to its home slot (reciprocal multiply, then a
//   short remainder step); the probe then reads one slot per cycle from the
//   single table memory and visits between 1 and TABLE_SIZE slots; each
//   read is registered before its slot is checked. The result passes
//   through a result register into the output register, and only then is
//   the next item taken.
//   An unused opcode skips the probe and answers not found.
// Reset:
//   After rst_n the slot marks are swept to empty, one slot per cycle, and
//   in_stall stays high until the sweep is done.
// Back-pressure:
//   The result sits in an output register; a new item is taken while it
//   waits. If the next result is ready while out_stall still holds the old
//   one, the block waits and keeps in_stall high.
// ============================================================================
module linear_probe_hash_table_core
  import lph_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [KEY_W-1:0]  in_key,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [SLOT_W-1:0] out_slot
);

  lph_cmd_t cmd;
  lph_sts_t sts;

  // sequencing: clear pass, hash, probe, result hand-off
  lph_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table memory, home-slot reduction, probe pipeline, result registers
  lph_dpath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_func    (in_func),
    .in_key     (in_key),
    .cmd        (cmd),
    .sts        (sts),
    .out_status (out_status),
    .out_slot   (out_slot)
  );

endmodule

>>> hw/rtl/lph_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// lph_checker - port-level assertions for the hash table core
// Watches the top-level ports only; attached by the bind below.
// ============================================================================
module lph_checker
  import lph_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [FUNC_W-1:0] in_func,
  input logic [KEY_W-1:0]  in_key,
  input logic              out_valid,
  input logic              out_stall,
  input logic [STAT_W-1:0] out_status,
  input logic [SLOT_W-1:0] out_slot
);

  // reset empties the output and holds off input during the clear sweep
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("output or input open right after reset");

  // one item in flight: an accepted item blocks the input next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted back to back");

  // a failed operation reports slot zero
  a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_slot == '0))
    else $error("nonzero slot on failed operation");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_slot))
    else $error("stalled result changed");

  // stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_func) && $stable(in_key))
    else $error("stalled input item changed");

endmodule

bind linear_probe_hash_table_core lph_checker u_lph_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_func    (in_func),
  .in_key     (in_key),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_status (out_status),
  .out_slot   (out_slot)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb - self-checking bench for linear_probe_hash_table_core
// Drives insert / search / delete items against a behavioral copy of the
// probed table and compares every result item in order. A directed opening
// covers wrap-around, duplicates, slot reuse, a full table and the spare
// opcode. It is followed by random fill and drain episodes over a small
// colliding key pool, under changing sender and receiver idle patterns.
// ============================================================================
module tb;
  import lph_pkg::*;

  localparam int SLOTS        = TABLE_SIZE_DEF;
  localparam int RAND_ITEMS   = 1750;
  localparam int POOL_SIZE    = 20;
  localparam int WARMUP_ITEMS = 30;    // first items run with no idling
  localparam int PHASE_LEN    = 150;   // items per idle phase
  localparam int HOLD_AT      = 340;   // accepted count that starts the long hold-off
  localparam int LONG_HOLD    = 400;   // cycles of unbroken out_stall
  localparam int DRAIN_CYCLES = 60;    // quiet cycles after the last result
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0]  KEY_MAX   = {KEY_W{1'b1}};

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    bit                pause;   // sender waits here until all results are back
  } table_op_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
  } table_reply_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic [FUNC_W-1:0] in_func   = FN_INSERT;
  logic [KEY_W-1:0]  in_key    = '0;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [SLOT_W-1:0] out_slot;

  // behavioral copy of the table
  logic [KEY_W-1:0]  tbl_keys  [SLOTS];
  logic [MARK_W-1:0] tbl_marks [SLOTS];

  table_op_t    ops_to_send [$];
  table_reply_t replies_due [$];

  int n_accepted = 0;
  int errors     = 0;
  bit in_taken   = 1'b0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  linear_probe_hash_table_core #(.TABLE_SIZE(SLOTS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_key     (in_key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_slot   (out_slot)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Apply one operation to the table copy and return its result item.
  function automatic table_reply_t apply_table_op(input logic [FUNC_W-1:0] func,
                                                  input logic [KEY_W-1:0]  key);
    table_reply_t r;
    int           s;
    int           n;
    bit           stop;
    r.status = ST_NOT_FOUND;
    r.slot   = '0;
    s        = int'({1'b0, key} % 32'(SLOTS));
    stop     = 1'b0;
    if (func == FN_INSERT) begin
      r.status = ST_FULL;
      // first slot not in use, tombstones included; no duplicate check
      for (n = 0; n < SLOTS && !stop; n++) begin
        if (tbl_marks[s] != MK_USED) begin
          tbl_keys[s]  = key;
          tbl_marks[s] = MK_USED;
          r.status     = ST_OK;
          r.slot       = SLOT_W'(s);
          stop         = 1'b1;
        end else begin
          s = (s + 1) % SLOTS;
        end
      end
    end else if (func == FN_SEARCH || func == FN_DELETE) begin
      // stops at an empty slot, skips tombstones, gives up after one lap
      for (n = 0; n < SLOTS && !stop; n++) begin
        if (tbl_marks[s] == MK_EMPTY) begin
          stop = 1'b1;
        end else if (tbl_marks[s] == MK_USED && tbl_keys[s] == key) begin
          if (func == FN_DELETE) tbl_marks[s] = MK_DELETED;
          r.status = ST_OK;
          r.slot   = SLOT_W'(s);
          stop     = 1'b1;
        end else begin
          s = (s + 1) % SLOTS;
        end
      end
    end
    return r;
  endfunction

  function automatic idle_mode_t idle_mode_now();
    if (n_accepted < WARMUP_ITEMS) return IDLE_NONE;
    case (((n_accepted - WARMUP_ITEMS) / PHASE_LEN) % 4)
      0:       return IDLE_NONE;
      1:       return IDLE_SEND;
      2:       return IDLE_RECV;
      default: return IDLE_BOTH;
    endcase
  endfunction

  task automatic queue_op(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key);
    table_op_t op;
    op.func  = func;
    op.key   = key;
    op.pause = 1'b0;
    ops_to_send.push_back(op);
  endtask

  task automatic queue_pause();
    table_op_t op;
    op.func  = FN_SEARCH;
    op.key   = '0;
    op.pause = 1'b1;
    ops_to_send.push_back(op);
  endtask

  // Sampling at the rising edge: predict accepted items, check results.
  always @(posedge clk) begin : scoreboard
    table_reply_t want;
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        replies_due.push_back(apply_table_op(in_func, in_key));
        n_accepted <= n_accepted + 1;
      end
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result item: status %0d slot %0d",
                   $time, out_status, out_slot);
          errors++;
        end else begin
          want = replies_due.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_status);
            errors++;
          end
          if (out_slot !== want.slot) begin
            $display("%0t: slot mismatch: expected %0d, actual %0d",
                     $time, want.slot, out_slot);
            errors++;
          end
        end
      end
    end
  end

  // Sender: holds a stalled item, otherwise offers the next one or idles.
  always @(negedge clk) begin : driver
    bit         busy;
    bit         gap;
    idle_mode_t mode;
    table_op_t  op;
    busy = in_valid && !in_taken;
    mode = idle_mode_now();
    gap  = (mode == IDLE_SEND && $urandom_range(99) < 45) ||
           (mode == IDLE_BOTH && $urandom_range(99) < 12);
    if (rst_n && !busy) begin
      if (ops_to_send.size() == 0) begin
        in_valid <= 1'b0;
      end else if (ops_to_send[0].pause) begin
        if (replies_due.size() == 0) void'(ops_to_send.pop_front());
        in_valid <= 1'b0;
      end else if (gap) begin
        in_valid <= 1'b0;
      end else begin
        op = ops_to_send.pop_front();
        in_valid <= 1'b1;
        in_func  <= op.func;
        in_key   <= op.key;
      end
    end
  end

  // Receiver: random stall per phase, plus one long hold-off that backs
  // the block up into its input while the sender keeps offering.
  always @(negedge clk) begin : receiver
    idle_mode_t mode;
    mode = idle_mode_now();
    if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (mode == IDLE_RECV) begin
      out_stall <= ($urandom_range(99) < 45);
    end else if (mode == IDLE_BOTH) begin
      out_stall <= ($urandom_range(99) < 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0]  pool [POOL_SIZE];
    logic [KEY_W-1:0]  key;
    logic [FUNC_W-1:0] func;
    bit                filling;
    int                i;
    int                r;

    for (i = 0; i < SLOTS; i++) begin
      tbl_keys[i]  = '0;
      tbl_marks[i] = MK_EMPTY;
    end

    // directed opening
    queue_op(FN_SEARCH, '0);              // empty table
    queue_op(FN_INSERT, KEY_MAX);         // home is the last slot
    queue_op(FN_INSERT, KEY_MAX);         // duplicate wraps to slot 0
    queue_op(FN_SEARCH, KEY_MAX);         // first copy
    queue_op(FN_DELETE, KEY_MAX);
    queue_op(FN_SEARCH, KEY_MAX);         // past the tombstone to the copy
    queue_op(FN_UNUSED, 31'h5);
    queue_op(FN_INSERT, '0);
    for (i = 0; i < 14; i++)              // thirteenth one reuses the tombstone
      queue_op(FN_INSERT, KEY_W'(16 * i + 3));
    queue_op(FN_INSERT, 31'h2AAA_AAAA);   // table full
    queue_op(FN_SEARCH, 31'h0555_5555);   // full lap, no empty slot
    queue_op(FN_DELETE, 31'h0555_5555);
    queue_pause();

    for (i = 0; i < POOL_SIZE; i++) begin
      pool[i] = KEY_W'($urandom());
      if (i % 2 == 0) pool[i][3:0] = ($urandom_range(1) != 0) ? 4'd3 : 4'd12;
    end
    pool[0] = '0;
    pool[1] = KEY_MAX;

    // random episodes: fill-biased or drain-biased, mostly pool keys
    filling = 1'b0;
    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i % 40 == 0) filling = ($urandom_range(1) != 0);
      if (i % 200 == 199) queue_pause();
      if (i % 25 == 24) begin
        r = $urandom_range(POOL_SIZE - 1);
        pool[r] = KEY_W'($urandom());
        if ($urandom_range(1) != 0) pool[r][3:0] = 4'(r);
      end
      r = $urandom_range(99);
      if (r < 3)                    func = FN_UNUSED;
      else if (r < (filling ? 58 : 23)) func = FN_INSERT;
      else if (r < (filling ? 83 : 53)) func = FN_SEARCH;
      else                          func = FN_DELETE;
      r = $urandom_range(99);
      if (r < 80)      key = pool[$urandom_range(POOL_SIZE - 1)];
      else if (r < 95) key = KEY_W'($urandom());
      else if (r < 97) key = KEY_MAX;
      else             key = KEY_W'($urandom_range(SLOTS - 1));
      queue_op(func, key);
    end

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    while (ops_to_send.size() != 0 || in_valid || replies_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (replies_due.size() != 0) begin
      $display("%0t: missing result items: expected %0d more, actual 0",
               $time, replies_due.size());
      errors++;
    end
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> linear_probe_hash_table_core.f
hw/rtl/lph_pkg.sv
hw/rtl/lph_ctrl.sv
hw/rtl/lph_dpath.sv
hw/rtl/linear_probe_hash_table_core.sv
hw/rtl/lph_checker.sv
verif/tb.sv
